FILE: hw/rtl/nfsa_pkg.sv
// Shared constants, request and status codes, and the bitmap command type
// for the next-fit slot allocator. No dependencies.
package nfsa_pkg;

  // Pool geometry
  localparam int POOL_SIZE = 64;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  // Fixed field widths
  localparam int REQ_W  = 2;
  localparam int ID_W   = 10;
  localparam int STAT_W = 2;
  localparam int LIM_W  = 7;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_ANY   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NAMED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_BAD   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_WRONG = 2'd3;

  // Command from the sequencer to the occupancy bitmap: one write, one read
  typedef struct packed {
    logic             wr;
    logic             wdata;
    logic [IDX_W-1:0] widx;
    logic [IDX_W-1:0] ridx;
  } nfsa_bm_cmd_t;

endpackage

FILE: hw/rtl/nfsa_bitmap.sv
// Occupancy bitmap of the slot pool: a one-bit memory with one write port
// and one registered read port. Depends on nfsa_pkg.
module nfsa_bitmap
  import nfsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  nfsa_bm_cmd_t cmd,
  output logic         rd
);

  logic occ [POOL_SIZE];

  // Update the addressed slot
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      occ[cmd.widx] <= cmd.wdata;
    end
  end

  // Register the addressed slot for the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
    end else begin
      rd <= occ[cmd.ridx];
    end
  end

endmodule

FILE: hw/rtl/next_fit_slot_allocator_core.sv
// Top level of the next-fit slot allocator: sequencer, scan stepper, counters
// and output register. Depends on nfsa_pkg and nfsa_bitmap.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+----------------------
//   in      | req_type, slot_id                        | in_valid / in_ready
//   out     | granted, slot_out, status, free_left     | out_valid / out_ready
//   cfg     | cfg_wdata (slot_limit)                   | cfg_we, no wait
//
// Named allocate, free and unknown requests are decided with no scan.
// Allocate-any steps one slot a cycle from the search pointer, a pace
// set by the single position stepper and bitmap read port.
// Reset or a limit write starts a sweep that clears one slot a cycle over
// all POOL_SIZE (64) slots, with the input held off until it ends.
// A result waiting on out_ready holds the sequencer in its final work cycle.
module next_fit_slot_allocator_core
  import nfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [ID_W-1:0]   slot_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              granted,
  output logic [IDX_W-1:0]  slot_out,
  output logic [STAT_W-1:0] status,
  output logic [CNT_W-1:0]  free_left,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WORK  = 2'd2;

  logic [1:0]       state;
  logic [REQ_W-1:0] req_r;
  logic [ID_W-1:0]  id_r;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] free_count;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] scan_p;
  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] clr_idx;

  logic             done;
  logic             fin;
  logic             res_ok;
  logic [STAT_W-1:0] res_stat;
  logic [IDX_W-1:0] res_slot;
  logic [CNT_W-1:0] free_count_next;
  logic [IDX_W-1:0] pos_next;
  logic             set_pos;
  logic             bm_rd;
  nfsa_bm_cmd_t     bm_cmd;
  logic [CNT_W-1:0] lim_new;
  logic [IDX_W-1:0] step_in;
  logic [IDX_W-1:0] step_out;
  logic [CNT_W-1:0] step_sum;
  logic             id_in_range;

  // Saturate the written limit into 1..POOL_SIZE
  always_comb begin
    if (cfg_wdata == '0) begin
      lim_new = CNT_W'(1);
    end else if (CNT_W'(cfg_wdata) > CNT_W'(POOL_SIZE)) begin
      lim_new = CNT_W'(POOL_SIZE);
    end else begin
      lim_new = CNT_W'(cfg_wdata);
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign id_in_range = (id_r < ID_W'(lim));

  // Shared position stepper: advance by one, wrapping at the limit
  assign step_in  = (req_r == REQ_ANY) ? scan_p : id_r[IDX_W-1:0];
  assign step_sum = CNT_W'(step_in) + CNT_W'(1);
  assign step_out = (step_sum >= lim) ? '0 : step_sum[IDX_W-1:0];

  // Decide the result of the current work cycle
  always_comb begin
    done            = 1'b1;
    res_ok          = 1'b0;
    res_stat        = STAT_WRONG;
    res_slot        = '0;
    free_count_next = free_count;
    pos_next        = pos;
    set_pos         = 1'b0;
    unique case (req_r)
      REQ_ANY: begin
        if (!bm_rd) begin
          res_ok   = 1'b1;
          res_stat = STAT_OK;
          res_slot = scan_p;
          pos_next = step_out;
          set_pos  = 1'b1;
          if (free_count != '0) free_count_next = free_count - CNT_W'(1);
        end else if (scan_cnt == lim - CNT_W'(1)) begin
          res_stat = STAT_NONE;
        end else begin
          done = 1'b0;
        end
      end
      REQ_NAMED: begin
        if (!id_in_range) begin
          res_stat = STAT_RANGE;
        end else if (!bm_rd) begin
          res_ok   = 1'b1;
          res_stat = STAT_OK;
          res_slot = id_r[IDX_W-1:0];
          pos_next = step_out;
          set_pos  = 1'b1;
          if (free_count != '0) free_count_next = free_count - CNT_W'(1);
        end
      end
      REQ_FREE: begin
        if (!id_in_range) begin
          res_stat = STAT_RANGE;
        end else if (bm_rd) begin
          res_ok   = 1'b1;
          res_stat = STAT_OK;
          res_slot = id_r[IDX_W-1:0];
          if (free_count < lim) free_count_next = free_count + CNT_W'(1);
        end
      end
      default: begin
        res_stat = STAT_WRONG;
      end
    endcase
  end

  assign fin = (state == S_WORK) && done && (!out_valid || out_ready);

  // Drive the bitmap: sweep to zero while clearing, set or release on a granted
  // item; read the slot that the next work cycle looks at
  always_comb begin
    bm_cmd.wr    = (state == S_CLEAR) || (fin && res_ok);
    bm_cmd.wdata = (state == S_CLEAR) ? 1'b0 : (req_r != REQ_FREE);
    bm_cmd.widx  = (state == S_CLEAR) ? clr_idx : step_in;
    if (state == S_IDLE) begin
      bm_cmd.ridx = (req_type == REQ_ANY) ? pos : slot_id[IDX_W-1:0];
    end else if (done) begin
      bm_cmd.ridx = step_in;
    end else begin
      bm_cmd.ridx = step_out;
    end
  end

  nfsa_bitmap u_bitmap (
    .clk (clk),
    .rst (rst),
    .cmd (bm_cmd),
    .rd  (bm_rd)
  );

  // Sequencer, pointer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      lim        <= CNT_W'(POOL_SIZE);
      free_count <= CNT_W'(POOL_SIZE);
      pos        <= '0;
      scan_p     <= '0;
      scan_cnt   <= '0;
    end else if (cfg_we) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      lim        <= lim_new;
      free_count <= lim_new;
      pos        <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(POOL_SIZE - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_WORK;
            scan_p   <= pos;
            scan_cnt <= '0;
          end
        end
        S_WORK: begin
          if (fin) begin
            state      <= S_IDLE;
            free_count <= free_count_next;
            if (set_pos) pos <= pos_next;
          end else if (!done) begin
            scan_p   <= step_out;
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= req_type;
      id_r  <= slot_id;
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      granted   <= res_ok;
      slot_out  <= res_slot;
      status    <= res_stat;
      free_left <= free_count_next;
    end
  end

  // Checks
  a_free_le_lim: assert property (@(posedge clk) disable iff (rst)
    free_count <= lim)
    else $error("free count above limit");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(pos) < lim)
    else $error("search pointer outside limit");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> status == STAT_OK)
    else $error("granted item without ok status");

  a_deny_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> slot_out == '0 && status != STAT_OK)
    else $error("denied item with slot or ok status");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cfg_we |=> !in_ready)
    else $error("ready straight after accept");

endmodule
